// ===== hdl/fsc_pkg.sv =====
// Package for the binary64 scale-by-power-of-two block: payload types,
// rounding-mode codes and the shared pow2 multiply-step function. No dependencies.
`default_nettype none
package fsc_pkg;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_ZERO    = 2'd1,
        RM_DOWN    = 2'd2,
        RM_UP      = 2'd3
    } rmode_t;

    typedef struct packed {
        logic [63:0]        value;
        logic signed [15:0] scale;
    } fsc_in_t;

    typedef struct packed {
        logic [63:0] product;
        logic        invalid_flag;
        logic        overflow_flag;
        logic        underflow_flag;
        logic        inexact_flag;
    } fsc_out_t;

    typedef struct packed {
        logic inv;
        logic ovf;
        logic unf;
        logic inx;
    } fsc_flags_t;

    typedef struct packed {
        logic [63:0] y;
        fsc_flags_t  fl;
    } fsc_step_t;

    localparam logic [63:0] MAX_FINITE = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INF_BITS   = 64'h7FF0_0000_0000_0000;
    localparam int          QUIET_POS  = 51;

    // Step exponent range fits in 12 signed bits.
    typedef logic signed [11:0] step_exp_t;

    // Position of leading one of a 52-bit fraction (nonzero), 0..51.
    function automatic logic [5:0] lead_pos(input logic [51:0] f);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 52; i++)
        begin
            if (f[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // One IEEE multiply of y by 2^e, e in [-1022, 1023].
    function automatic fsc_step_t mul_pow2(input logic [63:0] y, input step_exp_t e,
                                           input rmode_t mode, input fsc_flags_t fin);
        fsc_step_t  r;
        logic       sgn;
        logic [10:0] ex;
        logic [51:0] frac;
        logic [52:0] sig;
        logic signed [13:0] be;
        logic [5:0]  lp;
        logic [5:0]  shift;
        logic [52:0] kept;
        logic [52:0] rem;
        logic [52:0] half;
        logic        up;
        logic signed [13:0] sh_wide;
        sgn  = y[63];
        ex   = y[62:52];
        frac = y[51:0];
        r.y  = y;
        r.fl = fin;
        lp   = 6'd0;
        sig  = 53'd0;
        be   = 14'sd0;
        up   = 1'b0;
        if (ex == 11'h7FF)
        begin
            if (frac != 52'd0)
            begin
                if (!frac[QUIET_POS])
                begin
                    r.fl.inv = 1'b1;
                end
                r.y[QUIET_POS] = 1'b1;
            end
        end
        else if (!(ex == 11'd0 && frac == 52'd0))
        begin
            if (ex == 11'd0)
            begin
                lp  = lead_pos(frac);
                sig = {1'b0, frac} << (6'd52 - lp);
                be  = 14'sd1 - 14'(signed'({8'd0, 6'd52 - lp}));
            end
            else
            begin
                sig = {1'b1, frac};
                be  = 14'(signed'({3'd0, ex}));
            end
            be = be + 14'(e);
            if (be >= 14'sd2047)
            begin
                r.fl.ovf = 1'b1;
                r.fl.inx = 1'b1;
                if (mode == RM_ZERO || (mode == RM_DOWN && !sgn) || (mode == RM_UP && sgn))
                begin
                    r.y = {sgn, MAX_FINITE[62:0]};
                end
                else
                begin
                    r.y = {sgn, INF_BITS[62:0]};
                end
            end
            else if (be >= 14'sd1)
            begin
                r.y = {sgn, be[10:0], sig[51:0]};
            end
            else
            begin
                sh_wide = 14'sd1 - be;
                shift = (sh_wide > 14'sd62) ? 6'd62 : sh_wide[5:0];
                if (shift > 6'd53)
                begin
                    kept = 53'd0;
                    rem  = sig;
                end
                else
                begin
                    kept = sig >> shift;
                    rem  = sig & ((53'd1 << shift) - 53'd1);
                end
                half = (shift > 6'd53) ? 53'd0 : (53'd1 << (shift - 6'd1));
                case (mode)
                    RM_NEAREST: up = (shift > 6'd53) ? 1'b0 :
                                     ((rem > half) || (rem == half && kept[0]));
                    RM_DOWN:    up = sgn && (rem != 53'd0);
                    RM_UP:      up = !sgn && (rem != 53'd0);
                    default:    up = 1'b0;
                endcase
                kept = kept + 53'(up);
                if (rem != 53'd0)
                begin
                    r.fl.unf = 1'b1;
                    r.fl.inx = 1'b1;
                end
                r.y = {sgn, 10'd0, kept};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/float64_scale_by_power_of_two.sv =====
// Top level of the binary64 scale-by-power-of-two pipeline.
// Depends on fsc_pkg and fsc_stage.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one item: a
//   binary64 value and a signed 16-bit power of two. Output channel
//   (out_valid / out_stall / out_data) returns the scaled value and the
//   four sticky exception flags ORed over every multiply step.
//   cfg_we / cfg_wdata write the 2-bit rounding mode; write it only while
//   the pipeline is empty.
// Stages and throughput:
//   Three register stages, one per multiply step: first big step,
//   second big step, final step by the remainder. One item is accepted
//   every cycle while the output is not stalled.
// Stall:
//   A stage holds while it is full and its successor stalls; the stall
//   ripples back so nothing is dropped or repeated, and a bubble is filled
//   at once.
// Reset:
//   Clears all stage valid bits and sets rounding to nearest-even.
`default_nettype none
module float64_scale_by_power_of_two
    import fsc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire fsc_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output fsc_out_t      out_data
);
    rmode_t mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RM_NEAREST;
        end
        else if (cfg_we)
        begin
            mode_reg <= rmode_t'(cfg_wdata);
        end
    end

    fsc_step_t s0_in, s1_d, s2_d, s3_d;
    logic signed [17:0] n0, r1, r2, r3;
    rmode_t m1, m2, m3;
    logic v1, v2, v3, st1, st2, st3;
    logic en0, en1;
    step_exp_t e0, e1, e2;
    logic signed [17:0] rest0, rest1;

    assign s0_in.y  = in_data.value;
    assign s0_in.fl = '0;
    assign n0 = 18'(in_data.scale);

    // Stage 1: first big step.
    always_comb
    begin
        en0   = 1'b0;
        e0    = 12'sd0;
        rest0 = n0;
        if (n0 > 18'sd1023)
        begin
            en0   = 1'b1;
            e0    = 12'sd1023;
            rest0 = n0 - 18'sd1023;
        end
        else if (n0 < -18'sd1022)
        begin
            en0   = 1'b1;
            e0    = -12'sd1022;
            rest0 = n0 + 18'sd1022;
        end
    end

    fsc_stage u_st1 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(s0_in),
        .in_en(en0), .in_exp(e0), .in_rest(rest0), .in_mode(mode_reg),
        .out_valid(v1), .out_stall(st1), .out_data(s1_d),
        .out_rest(r1), .out_mode(m1)
    );

    // Stage 2: second big step; only taken when the first one was.
    always_comb
    begin
        en1   = 1'b0;
        e1    = 12'sd0;
        rest1 = r1;
        if (r1 > 18'sd1023)
        begin
            en1   = 1'b1;
            e1    = 12'sd1023;
            rest1 = r1 - 18'sd1023;
            if (rest1 > 18'sd1023)
            begin
                rest1 = 18'sd1023;
            end
        end
        else if (r1 < -18'sd1022)
        begin
            en1   = 1'b1;
            e1    = -12'sd1022;
            rest1 = r1 + 18'sd1022;
            if (rest1 < -18'sd1022)
            begin
                rest1 = -18'sd1022;
            end
        end
    end

    fsc_stage u_st2 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v1), .in_stall(st1), .in_data(s1_d),
        .in_en(en1), .in_exp(e1), .in_rest(rest1), .in_mode(m1),
        .out_valid(v2), .out_stall(st2), .out_data(s2_d),
        .out_rest(r2), .out_mode(m2)
    );

    // Stage 3: final step by the remainder, always taken.
    assign e2 = r2[11:0];

    fsc_stage u_st3 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v2), .in_stall(st2), .in_data(s2_d),
        .in_en(1'b1), .in_exp(e2), .in_rest(r2), .in_mode(m2),
        .out_valid(v3), .out_stall(st3), .out_data(s3_d),
        .out_rest(r3), .out_mode(m3)
    );

    assign st3       = out_stall;
    assign out_valid = v3;
    assign out_data  = {s3_d.y, s3_d.fl.inv, s3_d.fl.ovf, s3_d.fl.unf, s3_d.fl.inx};

    logic unused_tail;
    assign unused_tail = ^{r3, m3};
endmodule
`default_nettype wire

// ===== hdl/fsc_stage.sv =====
// One pipeline stage of the scale chain: an optional pow2 multiply step
// with valid/stall handling. Depends on fsc_pkg.
`default_nettype none
module fsc_stage
    import fsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire fsc_step_t  in_data,
    input  wire logic       in_en,
    input  wire step_exp_t  in_exp,
    input  wire logic signed [17:0] in_rest,
    input  wire rmode_t     in_mode,
    output logic            out_valid,
    input  wire logic       out_stall,
    output fsc_step_t       out_data,
    output logic signed [17:0] out_rest,
    output rmode_t          out_mode
);
    logic      valid_reg;
    fsc_step_t data_reg, data_next;
    logic signed [17:0] rest_reg;
    rmode_t    mode_reg;
    logic      load;

    assign in_stall = valid_reg && out_stall;
    assign load     = !in_stall;

    always_comb
    begin
        data_next = in_en ? mul_pow2(in_data.y, in_exp, in_mode, in_data.fl) : in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload while stalled.
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
            rest_reg <= in_rest;
            mode_reg <= in_mode;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_rest  = rest_reg;
    assign out_mode  = mode_reg;
endmodule
`default_nettype wire

// ===== verif/float64_scale_by_power_of_two_tb.sv =====
// Testbench for float64_scale_by_power_of_two: drives value/scale items under
// random idling, predicts each scaled result and its flags, and checks in order.
// Depends on fsc_pkg and the RTL of the block.
`default_nettype none
module float64_scale_by_power_of_two_tb;
    import fsc_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic [1:0] cfg_wdata;
    logic     in_valid;
    logic     in_stall;
    fsc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    fsc_out_t out_data;

    float64_scale_by_power_of_two dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Local copy of the rounding mode, tracked beside the block's register.
    rmode_t   cur_mode;
    // Scaled results still owed by the block, oldest first.
    fsc_out_t owed_products[$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // One rounded multiply by 2^e, e within [-1022, 1023]; accumulates flags.
    function automatic logic [63:0] scale_step(input logic [63:0] y, input int e,
                                              input rmode_t m, inout logic [3:0] fl);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] frac;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          be;
        int          sh;
        logic        up;
        sgn  = y[63];
        ex   = y[62:52];
        frac = y[51:0];
        if (ex == 11'h7FF)
        begin
            if (frac != 0)
            begin
                if (!frac[51])
                begin
                    fl[3] = 1'b1;
                end
                return y | 64'h0008_0000_0000_0000;
            end
            return y;
        end
        if (ex == 0 && frac == 0)
        begin
            return y;
        end
        if (ex == 0)
        begin
            sig = {12'd0, frac};
            be  = 1;
            while (!sig[52])
            begin
                sig = sig << 1;
                be--;
            end
        end
        else
        begin
            sig = {11'd0, 1'b1, frac};
            be  = ex;
        end
        be = be + e;
        if (be >= 2047)
        begin
            fl[2] = 1'b1;
            fl[0] = 1'b1;
            if (m == RM_ZERO || (m == RM_DOWN && !sgn) || (m == RM_UP && sgn))
            begin
                return {sgn, 63'h7FEF_FFFF_FFFF_FFFF};
            end
            return {sgn, 63'h7FF0_0000_0000_0000};
        end
        if (be >= 1)
        begin
            return {sgn, be[10:0], sig[51:0]};
        end
        sh = 1 - be;
        if (sh > 62)
        begin
            sh = 62;
        end
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        case (m)
            RM_NEAREST: up = (rem > half) || (rem == half && kept[0]);
            RM_DOWN:    up = sgn && rem != 0;
            RM_UP:      up = !sgn && rem != 0;
            default:    up = 1'b0;
        endcase
        kept = kept + up;
        if (rem != 0)
        begin
            fl[1] = 1'b1;
            fl[0] = 1'b1;
        end
        return {sgn, 63'(kept)};
    endfunction

    // Full scalbn chain: up to two big steps, then the clamped remainder.
    function automatic fsc_out_t scaled_product(input fsc_in_t it, input rmode_t m);
        fsc_out_t   r;
        logic [63:0] y;
        logic [3:0] fl;   // inv, ovf, unf, inx
        int         n;
        y  = it.value;
        n  = it.scale;
        fl = 4'd0;
        if (n > 1023)
        begin
            y = scale_step(y, 1023, m, fl);
            n -= 1023;
            if (n > 1023)
            begin
                y = scale_step(y, 1023, m, fl);
                n -= 1023;
                if (n > 1023)
                begin
                    n = 1023;
                end
            end
        end
        else if (n < -1022)
        begin
            y = scale_step(y, -1022, m, fl);
            n += 1022;
            if (n < -1022)
            begin
                y = scale_step(y, -1022, m, fl);
                n += 1022;
                if (n < -1022)
                begin
                    n = -1022;
                end
            end
        end
        y = scale_step(y, n, m, fl);
        r.product        = y;
        r.invalid_flag   = fl[3];
        r.overflow_flag  = fl[2];
        r.underflow_flag = fl[1];
        r.inexact_flag   = fl[0];
        return r;
    endfunction

    // Present one item after optional random idling, hold it until accepted, and leave
    // valid high. Valid stays high across back-to-back items with no re-raise.
    task automatic send_item(input logic [63:0] v, input logic signed [15:0] s);
        fsc_in_t it;
        it.value = v;
        it.scale = s;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        owed_products.push_back(scaled_product(it, cur_mode));
    endtask

    // Lower valid after the last item of a burst.
    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every owed result, then let the pipeline drain.
    task automatic wait_empty();
        while (owed_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic set_mode(input rmode_t m);
        wait_empty();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_mode = m;
        @(posedge clk);
    endtask

    // Random binary64 patterns, weighted toward the edges of the exponent range and single-bit fractions.
    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v[62:52] = 11'h000;
            1: v[62:52] = 11'h7FF;
            2: v[62:52] = 11'(1 + $urandom_range(60));
            3: v[62:52] = 11'(2046 - $urandom_range(60));
            4: v[51:0]  = 52'(64'd1 << $urandom_range(51));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] rand_scale();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($signed(-1100 + $urandom_range(100)));
            2: return 16'($signed(1000 + $urandom_range(100)));
            3: return 16'($signed(-2200 + $urandom_range(300)));
            4: return 16'($signed(2000 + $urandom_range(200)));
            default: return 16'($signed($urandom_range(120)) - 60);
        endcase
    endfunction

    // Directed: field extremes, NaNs of both kinds, infinities, zeros, overflow,
    // subnormal rounding with double rounding, and saturated scales.
    task automatic test_directed();
        logic [63:0] vals[12];
        logic signed [15:0] scl[7];
        vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001,
                 64'hFFF8_0000_0000_0000, 64'h0000_0000_0000_0001,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'hBFF8_0000_0000_0000,
                 64'h0018_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h3FF0_0000_0000_0003};
        scl = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1074, 16'sd1024, -16'sd1023,
                -16'sd2100};
        for (int m = 0; m < 4; m++)
        begin
            set_mode(rmode_t'(m));
            for (int i = 0; i < 12; i++)
            begin
                send_item(vals[i], scl[i % 7]);
            end
            send_item(64'h3FF0_0000_0000_0001, -16'sd1075);
            send_item(64'hBFF0_0000_0000_0001, -16'sd1060);
            drop_valid();
        end
    endtask

    // Random items in four phases of idling and receiver stall, in random rounding modes.
    task automatic test_random();
        int per_phase;
        per_phase = 460;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 56) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 56) : 0;
            for (int k = 0; k < per_phase; k++)
            begin
                if (k % 115 == 0)
                begin
                    drop_valid();
                    set_mode(rmode_t'($urandom_range(3)));
                end
                send_item(rand_double(), rand_scale());
            end
            drop_valid();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Check each accepted result against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result %h", out_data);
                end
            end
            else
            begin
                fsc_out_t exp_r;
                exp_r = owed_products.pop_front();
                if (exp_r.product != out_data.product
                    || exp_r.invalid_flag != out_data.invalid_flag
                    || exp_r.overflow_flag != out_data.overflow_flag
                    || exp_r.underflow_flag != out_data.underflow_flag
                    || exp_r.inexact_flag != out_data.inexact_flag)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected %h/%b%b%b%b got %h/%b%b%b%b",
                                 exp_r.product, exp_r.invalid_flag, exp_r.overflow_flag,
                                 exp_r.underflow_flag, exp_r.inexact_flag,
                                 out_data.product, out_data.invalid_flag,
                                 out_data.overflow_flag, out_data.underflow_flag,
                                 out_data.inexact_flag);
                    end
                end
            end
        end
    end

    // Receiver stall, drawn fresh each edge.
    always @(posedge clk)
    begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000)
        begin
            $display("float64_scale_by_power_of_two_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 2'd0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cur_mode       = RM_NEAREST;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        wait_empty();
        if (mismatch_count == 0 && owed_products.size() == 0)
        begin
            $display("float64_scale_by_power_of_two_tb: clean");
        end
        else
        begin
            $display("float64_scale_by_power_of_two_tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== float64_scale_by_power_of_two.f =====
hdl/fsc_pkg.sv
hdl/fsc_stage.sv
hdl/float64_scale_by_power_of_two.sv
verif/float64_scale_by_power_of_two_tb.sv
